### rtl/smpcf_pkg.sv
// shared types and constants for the shadow map pcf lookup
// item structs, controller command and status structs, fixed-point constants
// no dependencies
package smpcf_pkg;

  // default edge length of the square depth map
  localparam int DEF_MAP_SIZE = 256;

  // light coordinate accumulator, q.20, holds three products plus offset
  localparam int ACC_W = 34;

  // 1.0 in q.20 and 0.001 in q.20 rounded to nearest
  localparam int ONE_Q20 = 1048576;
  localparam int EPS_Q20 = 1049;

  // largest q3.12 depth, the cleared value of every cell
  localparam logic [15:0] DEPTH_MAX = 16'h7fff;

  // item kinds
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z = 2'd2;

  // step counter for the nine products and the nine taps
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] LAST_STEP = 4'd9;

  typedef struct packed {
    logic               func;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [7:0]         cell_col;
    logic [7:0]         cell_row;
    logic signed [15:0] new_depth;
  } in_item_t;

  typedef struct packed {
    logic [3:0] hit_count;
    logic       outside_frustum;
  } out_item_t;

  typedef struct packed {
    logic              clr_en;
    logic              load;
    logic              use_wr_addr;
    logic              wr_upd;
    logic              mul_en;
    logic [STEP_W-1:0] mul_sel;
    logic              acc_en;
    logic [STEP_W-1:0] acc_sel;
    logic              cell_en;
    logic [STEP_W-1:0] tap_sel;
    logic              cmp_en;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic outside;
  } sts_t;

endpackage

### rtl/smpcf_ctrl.sv
// controller state machine for the shadow map pcf lookup
// sequences clear sweep, depth write, transform and the nine taps
// depends on smpcf_pkg
module smpcf_ctrl
  import smpcf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_func,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_WR_RD  = 3'd2;
  localparam logic [2:0] ST_WR_UPD = 3'd3;
  localparam logic [2:0] ST_XFORM  = 3'd4;
  localparam logic [2:0] ST_CELL   = 3'd5;
  localparam logic [2:0] ST_TAP    = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = (in_func == FUNC_QUERY) ? ST_XFORM : ST_WR_RD;
        end
      end
      ST_WR_RD: begin
        cmd.use_wr_addr = 1'b1;
        state_nxt       = ST_WR_UPD;
      end
      ST_WR_UPD: begin
        cmd.use_wr_addr = 1'b1;
        cmd.wr_upd      = 1'b1;
        state_nxt       = ST_IDLE;
      end
      ST_XFORM: begin
        // product k is formed while product k-1 is summed
        cmd.mul_en  = (step_r != LAST_STEP);
        cmd.mul_sel = step_r;
        cmd.acc_en  = (step_r != '0);
        cmd.acc_sel = step_r - STEP_W'(1);
        if (step_r == LAST_STEP) begin
          state_nxt = ST_CELL;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_CELL: begin
        cmd.cell_en = 1'b1;
        step_nxt    = '0;
        state_nxt   = ST_TAP;
      end
      ST_TAP: begin
        if (sts.outside) begin
          state_nxt = ST_DONE;
        end else begin
          // tap k is addressed while tap k-1 is compared
          cmd.tap_sel = step_r;
          cmd.cmp_en  = (step_r != '0);
          if (step_r == LAST_STEP) begin
            state_nxt = ST_DONE;
          end else begin
            step_nxt = step_r + STEP_W'(1);
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

### rtl/smpcf_dp.sv
// datapath for the shadow map pcf lookup
// config rows, shared multiplier, cell mapping, depth store and hit counter
// depends on smpcf_pkg
module smpcf_dp
  import smpcf_pkg::*;
#(
  parameter int MAP_SIZE = DEF_MAP_SIZE
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_item_t             in_item,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  input  cmd_t                 cmd,
  output sts_t                 sts
);

  localparam int CELLS = MAP_SIZE * MAP_SIZE;
  localparam int AW    = $clog2(CELLS);
  localparam int CIW   = $clog2(MAP_SIZE);
  localparam int MW    = $clog2(MAP_SIZE + 1);

  localparam logic signed [ACC_W-1:0] POS_ONE = ACC_W'(ONE_Q20);
  localparam logic signed [ACC_W-1:0] NEG_ONE = -POS_ONE;
  localparam logic [ACC_W:0]          EPS_EXT = (ACC_W + 1)'(EPS_Q20);
  localparam logic [CIW-1:0]          IDX_MAX = CIW'(MAP_SIZE - 1);

  // neighbour offset codes, also used as row/term codes of the transform
  localparam logic [1:0] OFS_LO  = 2'd0;
  localparam logic [1:0] OFS_MID = 2'd1;
  localparam logic [1:0] OFS_HI  = 2'd2;

  logic [63:0] row_x_r, row_y_r, row_z_r;
  in_item_t    item_r;

  logic signed [31:0]      prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] lx_r, ly_r, lz_r;
  logic signed [ACC_W:0]   ref_r;
  logic                    outside_r;
  logic [CIW-1:0]          cx_r, cy_r;
  logic [3:0]              hit_r;
  out_item_t               out_item_r;

  logic [AW-1:0]      clr_addr_r;
  logic [15:0]        mem [CELLS];
  logic signed [15:0] rd_r;

  // split a step number into row code (upper) and column/term code (lower)
  function automatic logic [3:0] split_step(input logic [STEP_W-1:0] s);
    logic [3:0] r;
    case (s)
      4'd0:    r = {OFS_LO, OFS_LO};
      4'd1:    r = {OFS_LO, OFS_MID};
      4'd2:    r = {OFS_LO, OFS_HI};
      4'd3:    r = {OFS_MID, OFS_LO};
      4'd4:    r = {OFS_MID, OFS_MID};
      4'd5:    r = {OFS_MID, OFS_HI};
      4'd6:    r = {OFS_HI, OFS_LO};
      4'd7:    r = {OFS_HI, OFS_MID};
      4'd8:    r = {OFS_HI, OFS_HI};
      default: r = {OFS_MID, OFS_MID};
    endcase
    return r;
  endfunction

  function automatic logic is_outside(input logic signed [ACC_W-1:0] c);
    return (c < NEG_ONE) || (c > POS_ONE);
  endfunction

  // floor((c + 1) * map_size / 2), clamped at the top edge
  function automatic logic [CIW-1:0] to_cell(input logic signed [ACC_W-1:0] c);
    logic [21:0]    t;
    logic [21+MW:0] p;
    logic [MW:0]    idx;
    t   = c[21:0] + 22'(ONE_Q20);
    p   = (22 + MW)'(t) * (22 + MW)'(MAP_SIZE);
    idx = p[21+MW:21];
    if (idx > (MW + 1)'(MAP_SIZE - 1)) begin
      return IDX_MAX;
    end
    return idx[CIW-1:0];
  endfunction

  function automatic logic [CIW-1:0] nbr(input logic [CIW-1:0] i, input logic [1:0] d);
    logic [CIW-1:0] r;
    case (d)
      OFS_LO:  r = (i == '0) ? i : i - CIW'(1);
      OFS_HI:  r = (i == IDX_MAX) ? i : i + CIW'(1);
      default: r = i;
    endcase
    return r;
  endfunction

  // configuration rows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_x_r <= '0;
      row_y_r <= '0;
      row_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW_X: row_x_r <= cfg_data;
        CFG_ROW_Y: row_y_r <= cfg_data;
        CFG_ROW_Z: row_z_r <= cfg_data;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
  end

  // multiplier operands
  logic [3:0]         mul_code;
  logic [63:0]        mul_row;
  logic signed [15:0] coef, pos;

  always_comb begin
    mul_code = split_step(cmd.mul_sel);
    case (mul_code[3:2])
      OFS_LO:  mul_row = row_x_r;
      OFS_MID: mul_row = row_y_r;
      default: mul_row = row_z_r;
    endcase
    case (mul_code[1:0])
      OFS_LO: begin
        coef = mul_row[15:0];
        pos  = item_r.pos_x;
      end
      OFS_MID: begin
        coef = mul_row[31:16];
        pos  = item_r.pos_y;
      end
      default: begin
        coef = mul_row[47:32];
        pos  = item_r.pos_z;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= 32'(coef) * 32'(pos);
    end
  end

  // accumulate: first term picks up the offset, last term lands in the coordinate
  logic [3:0]              acc_code;
  logic [15:0]             off;
  logic signed [ACC_W-1:0] off_ext, prod_ext, acc_sum;

  always_comb begin
    acc_code = split_step(cmd.acc_sel);
    case (acc_code[3:2])
      OFS_LO:  off = row_x_r[63:48];
      OFS_MID: off = row_y_r[63:48];
      default: off = row_z_r[63:48];
    endcase
    off_ext  = {{(ACC_W - 24){off[15]}}, off, 8'h00};
    prod_ext = {{(ACC_W - 32){prod_r[31]}}, prod_r};
    acc_sum  = ((acc_code[1:0] == OFS_LO) ? off_ext : acc_r) + prod_ext;
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      acc_r <= acc_sum;
      if (acc_code[1:0] == OFS_HI) begin
        case (acc_code[3:2])
          OFS_LO:  lx_r <= acc_sum;
          OFS_MID: ly_r <= acc_sum;
          default: lz_r <= acc_sum;
        endcase
      end
    end
  end

  // cube test, cell mapping and reference depth
  always_ff @(posedge clk) begin
    if (cmd.cell_en) begin
      outside_r <= is_outside(lx_r) || is_outside(ly_r) || is_outside(lz_r);
      cx_r      <= to_cell(lx_r);
      cy_r      <= to_cell(ly_r);
      ref_r     <= {lz_r[ACC_W-1], lz_r} - EPS_EXT;
    end
  end

  // depth store addressing
  logic [3:0]    tap_code;
  logic [AW-1:0] tap_addr, wr_addr, mem_addr;
  logic          in_map, mem_we;
  logic [15:0]   mem_wdata;

  always_comb begin
    tap_code = split_step(cmd.tap_sel);
    tap_addr = AW'(nbr(cy_r, tap_code[3:2])) * AW'(MAP_SIZE)
             + AW'(nbr(cx_r, tap_code[1:0]));
    wr_addr  = AW'(item_r.cell_row) * AW'(MAP_SIZE) + AW'(item_r.cell_col);
    in_map   = ((MW + 8)'(item_r.cell_col) < (MW + 8)'(MAP_SIZE))
            && ((MW + 8)'(item_r.cell_row) < (MW + 8)'(MAP_SIZE));
    if (cmd.clr_en) begin
      mem_addr = clr_addr_r;
    end else if (cmd.use_wr_addr) begin
      mem_addr = wr_addr;
    end else begin
      mem_addr = tap_addr;
    end
    mem_we    = cmd.clr_en || (cmd.wr_upd && in_map && (item_r.new_depth < rd_r));
    mem_wdata = cmd.clr_en ? DEPTH_MAX : item_r.new_depth;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_en) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_r <= mem[mem_addr];
  end

  // hit counting against the tap read in the previous cycle
  logic signed [ACC_W:0] dep_ext;

  assign dep_ext = {{(ACC_W - 23){rd_r[15]}}, rd_r, 8'h00};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit_r <= '0;
    end else if (cmd.cmp_en && (ref_r > dep_ext)) begin
      hit_r <= hit_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item_r.hit_count       <= outside_r ? 4'd0 : hit_r;
      out_item_r.outside_frustum <= outside_r;
    end
  end

  assign out_item     = out_item_r;
  assign sts.clr_last = (clr_addr_r == AW'(CELLS - 1));
  assign sts.outside  = outside_r;

endmodule

### rtl/shadow_map_pcf_lookup.sv
// top level of the shadow map lookup with 3x3 percentage-closer filtering
// joins the controller and the datapath
// depends on smpcf_pkg, smpcf_ctrl, smpcf_dp
//
// A square store of MAP_SIZE x MAP_SIZE signed q3.12 depths sits in one
// single-ported memory. After reset the block sweeps the whole store to the
// largest depth, one cell a cycle, holding in_stall high until the sweep
// ends; configuration writes are taken during the sweep. A write item
// (func 0) reads its cell and lowers it in the next cycle if the new depth
// is smaller, with no result. A query item (func 1) forms the light x, y and
// depth on a single shared 16x16 multiplier, nine products in turn, maps the
// point to a cell and then reads the nine neighbours through the one memory
// port, one tap per cycle (no taps are read when the point lies outside the
// unit cube). The result waits in an output register, so a new item is
// accepted while it is still stalled; a query only finishes once that
// register is free. The user must write the three coefficient rows through
// the cfg port only while the block is idle; the block does not enforce it.
module shadow_map_pcf_lookup
  import smpcf_pkg::*;
#(
  parameter int MAP_SIZE = DEF_MAP_SIZE
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input items
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  // result items
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  // coefficient rows
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // sequencing of clear, write and query steps
  smpcf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_item.func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic, depth store and result register
  smpcf_dp #(
    .MAP_SIZE (MAP_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
